// File: src/key_matrix_scanner_event_queue_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef KEY_MATRIX_SCANNER_EVENT_QUEUE_MACROS_SVH
`define KEY_MATRIX_SCANNER_EVENT_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// The property holds at every clock edge outside reset.
`define KMSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The antecedent in one cycle implies the consequent in the next.
`define KMSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KMSQ_ASSERT(lbl, prop, msg)
`define KMSQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/kmsq_pkg.sv
`timescale 1ns / 1ps
package kmsq_pkg;

  localparam int NUM_COLUMNS = 17;
  localparam int RING_DEPTH  = 8;

  localparam int NUM_ROWS   = 4;
  localparam int ROW_W      = 2;
  localparam int COL_W      = 5;
  localparam int CODE_W     = 8;
  localparam int KEY_IDX_W  = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int RING_PTR_W = $clog2(RING_DEPTH);
  localparam int RING_CNT_W = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_RESET    = 2'd0,
    PH_CLK_LOW  = 2'd1,
    PH_CLK_HIGH = 2'd2
  } phase_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CODE_W-1:0] push_code;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } ring_stat_t;

endpackage

// File: src/kmsq_key_store.sv
`timescale 1ns / 1ps
module kmsq_key_store
  import kmsq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [KEY_IDX_W-1:0] addr,
  input  logic [NUM_ROWS-1:0]  wr_data,
  output logic [NUM_ROWS-1:0]  rd_data
);

  logic [NUM_ROWS-1:0] levels_r [NUM_COLUMNS];

  // The column index never reaches NUM_COLUMNS, so the read stays in range.
  assign rd_data = levels_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        levels_r[i] <= '0;
      end
    end else if (wr_en) begin
      levels_r[addr] <= wr_data;
    end
  end

endmodule

// File: src/kmsq_event_ring.sv
`timescale 1ns / 1ps
module kmsq_event_ring
  import kmsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ring_ctrl_t        ctrl,
  output ring_stat_t        stat,
  output logic [CODE_W-1:0] rd_code
);

  logic [CODE_W-1:0]     slots_r [RING_DEPTH];
  logic [RING_PTR_W-1:0] head_r, head_nxt;
  logic [RING_PTR_W-1:0] tail_r, tail_nxt;
  logic [RING_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == RING_CNT_W'(RING_DEPTH));
  assign stat.last  = (count_r == RING_CNT_W'(1));
  assign rd_code    = slots_r[head_r];

  assign do_push = ctrl.push && !stat.full;
  assign do_pop  = ctrl.pop && !stat.empty;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == RING_PTR_W'(RING_DEPTH - 1)) ? '0 : tail_r + RING_PTR_W'(1);
    end
    if (do_pop) begin
      head_nxt = (head_r == RING_PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + RING_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + RING_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - RING_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[tail_r] <= ctrl.push_code;
    end
  end

endmodule

// File: src/key_matrix_scanner_event_queue.sv
`timescale 1ns / 1ps
`include "key_matrix_scanner_event_queue_macros.svh"
// Key matrix scanner with an event queue. Each transaction is either a scan
// tick or a pop. For a pop and for a tick in the reset or clock-high phase,
// the result passes through the EXEC and DONE states and is then loaded
// into the output register. For a tick in the clock-low phase it passes
// through EXEC, CMP and DONE, since one comparator walks the four row bits
// one per cycle in CMP and pushes at most one event per cycle into the ring.
// The input is stalled from acceptance until the result is loaded, so no
// new transaction is accepted before the last result is loaded. A result
// that still waits downstream holds the block only when the next result is
// ready to load. The key store is cleared directly by reset, so no clearing
// pass follows reset.
module key_matrix_scanner_event_queue
  import kmsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [3:0]        in_row_sense,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_reset_line,
  output logic              out_clock_line,
  output logic              out_event_valid,
  output logic [CODE_W-1:0] out_event_code,
  output logic              out_pending
);

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  phase_t              phase_r, phase_nxt;
  logic [NUM_ROWS-1:0] rows_r, rows_nxt;
  logic [NUM_ROWS-1:0] old_r, old_nxt;
  logic [ROW_W-1:0]    row_idx_r, row_idx_nxt;
  logic [COL_W-1:0]    column_r, column_nxt;
  logic                reset_level_r, reset_level_nxt;
  logic                clock_level_r, clock_level_nxt;
  logic                pending_r, pending_nxt;
  logic                ev_valid_r, ev_valid_nxt;
  logic [CODE_W-1:0]   ev_code_r, ev_code_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_reset_line_r, out_reset_line_nxt;
  logic                out_clock_line_r, out_clock_line_nxt;
  logic                out_event_valid_r, out_event_valid_nxt;
  logic [CODE_W-1:0]   out_event_code_r, out_event_code_nxt;
  logic                out_pending_r, out_pending_nxt;

  logic                out_load;
  logic                key_wr;
  logic [NUM_ROWS-1:0] key_rd;
  logic                row_changed;
  ring_ctrl_t          ring_ctrl;
  ring_stat_t          ring_stat;
  logic [CODE_W-1:0]   ring_rd_code;

  kmsq_key_store u_key_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (key_wr),
    .addr    (column_r[KEY_IDX_W-1:0]),
    .wr_data (rows_r),
    .rd_data (key_rd)
  );

  kmsq_event_ring u_event_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ring_ctrl),
    .stat    (ring_stat),
    .rd_code (ring_rd_code)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign row_changed = (old_r[row_idx_r] != rows_r[row_idx_r]);

  assign out_valid       = out_valid_r;
  assign out_reset_line  = out_reset_line_r;
  assign out_clock_line  = out_clock_line_r;
  assign out_event_valid = out_event_valid_r;
  assign out_event_code  = out_event_code_r;
  assign out_pending     = out_pending_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_r == OP_TICK && phase_r == PH_CLK_LOW) state_nxt = ST_CMP;
        else state_nxt = ST_DONE;
      end
      ST_CMP: begin
        if (row_idx_r == ROW_W'(NUM_ROWS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt          = op_r;
    phase_nxt       = phase_r;
    rows_nxt        = rows_r;
    old_nxt         = old_r;
    row_idx_nxt     = row_idx_r;
    column_nxt      = column_r;
    reset_level_nxt = reset_level_r;
    clock_level_nxt = clock_level_r;
    pending_nxt     = pending_r;
    ev_valid_nxt    = ev_valid_r;
    ev_code_nxt     = ev_code_r;
    key_wr          = 1'b0;
    ring_ctrl       = '0;

    out_valid_nxt       = out_valid_r && out_stall;
    out_reset_line_nxt  = out_reset_line_r;
    out_clock_line_nxt  = out_clock_line_r;
    out_event_valid_nxt = out_event_valid_r;
    out_event_code_nxt  = out_event_code_r;
    out_pending_nxt     = out_pending_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = op_t'(in_operation);
          rows_nxt     = in_row_sense;
          ev_valid_nxt = 1'b0;
          ev_code_nxt  = '0;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_POP) begin
          if (ring_stat.empty) begin
            pending_nxt = 1'b0;
          end else begin
            ring_ctrl.pop = 1'b1;
            ev_valid_nxt  = 1'b1;
            ev_code_nxt   = ring_rd_code;
            if (ring_stat.last) pending_nxt = 1'b0;
          end
        end else begin
          case (phase_r)
            PH_CLK_LOW: begin
              key_wr          = 1'b1;
              old_nxt         = key_rd;
              row_idx_nxt     = '0;
              clock_level_nxt = 1'b1;
              phase_nxt       = PH_CLK_HIGH;
            end
            PH_CLK_HIGH: begin
              if (column_r == COL_W'(NUM_COLUMNS - 1)) column_nxt = '0;
              else column_nxt = column_r + COL_W'(1);
              clock_level_nxt = 1'b0;
              phase_nxt       = PH_CLK_LOW;
            end
            default: begin
              clock_level_nxt = 1'b0;
              reset_level_nxt = 1'b1;
              phase_nxt       = PH_CLK_LOW;
            end
          endcase
        end
      end
      ST_CMP: begin
        // A change raises the flag even when the ring is full and drops it.
        if (row_changed) begin
          pending_nxt         = 1'b1;
          ring_ctrl.push      = 1'b1;
          ring_ctrl.push_code = {old_r[row_idx_r], column_r, row_idx_r};
        end
        row_idx_nxt = row_idx_r + ROW_W'(1);
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt       = 1'b1;
          out_reset_line_nxt  = reset_level_r;
          out_clock_line_nxt  = clock_level_r;
          out_event_valid_nxt = ev_valid_r;
          out_event_code_nxt  = ev_code_r;
          out_pending_nxt     = pending_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_RESET;
      column_r      <= '0;
      reset_level_r <= 1'b0;
      clock_level_r <= 1'b0;
      pending_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      column_r      <= column_nxt;
      reset_level_r <= reset_level_nxt;
      clock_level_r <= clock_level_nxt;
      pending_r     <= pending_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r              <= op_nxt;
    rows_r            <= rows_nxt;
    old_r             <= old_nxt;
    row_idx_r         <= row_idx_nxt;
    ev_valid_r        <= ev_valid_nxt;
    ev_code_r         <= ev_code_nxt;
    out_reset_line_r  <= out_reset_line_nxt;
    out_clock_line_r  <= out_clock_line_nxt;
    out_event_valid_r <= out_event_valid_nxt;
    out_event_code_r  <= out_event_code_nxt;
    out_pending_r     <= out_pending_nxt;
  end

  // Every queued event has raised the flag, and the flag drops only on drain.
  `KMSQ_ASSERT(a_pending_covers_ring, !pending_r |-> ring_stat.empty, "queued without pending")
  // The counter clock is high exactly in the clock-high phase.
  `KMSQ_ASSERT(a_clock_matches_phase, clock_level_r == (phase_r == PH_CLK_HIGH), "clock vs phase")
  // An accepted transaction always starts execution in the next cycle.
  `KMSQ_ASSERT_NEXT(a_accept_starts_exec, in_valid && !in_stall, state_r == ST_EXEC, "no exec")

endmodule
